>>> rtl/bfrb_pkg.sv
// Package for the box filter with replicated borders.
// Holds geometry constants, the controller state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package bfrb_pkg;

  localparam int MaxWidth = 1024;
  localparam int MaxRadius = 7;
  localparam int Slots = 2 * MaxRadius + 1;
  localparam int ColW = $clog2(MaxWidth);
  localparam int SlotW = $clog2(Slots);
  localparam int StoreDepth = Slots * MaxWidth;
  localparam int AddrW = SlotW + ColW;
  localparam int RowW = 13;
  localparam int HRowW = 12;
  localparam int SumW = 16;
  localparam int CfgW = 13;

  typedef enum logic [1:0] {
    CfgWindowSize  = 2'd0,
    CfgFrameWidth  = 2'd1,
    CfgFrameHeight = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StFlush,
    StLoad,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic accept;
    logic col_start;
    logic rd_step;
    logic div_load;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic rd_last;
    logic div_last;
    logic col_last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/bfrb_ctrl.sv
// Controller for the box filter: sequences window reads, division and output.
// Depends on bfrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfrb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire bfrb_pkg::sts_t sts_i,
  output bfrb_pkg::cmd_t     cmd_o
);
  import bfrb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && sts_i.emit) state_d = StRead;
      end
      StRead: begin
        if (sts_i.rd_last) state_d = StFlush;
      end
      StFlush: state_d = StLoad;
      StLoad:  state_d = StDiv;
      StDiv: begin
        if (sts_i.div_last) state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready) state_d = sts_i.col_last ? StIdle : StRead;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        cmd_o.accept = s_axis_tvalid;
        cmd_o.col_start = s_axis_tvalid && sts_i.emit;
      end
      StRead:  cmd_o.rd_step = 1'b1;
      StFlush: ;
      StLoad:  cmd_o.div_load = 1'b1;
      StDiv:   cmd_o.div_step = 1'b1;
      StOut: begin
        m_axis_tvalid = 1'b1;
        cmd_o.col_start = m_axis_tready && !sts_i.col_last;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/bfrb_datapath.sv
// Datapath for the box filter: registers, counters, line store, accumulator, divider.
// Depends on bfrb_pkg; driven by bfrb_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bfrb_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [bfrb_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic [7:0]               s_axis_tdata,
  input  wire logic                     s_axis_tuser,
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,
  input  wire bfrb_pkg::cmd_t           cmd_i,
  output bfrb_pkg::sts_t                sts_o
);
  import bfrb_pkg::*;

  logic [3:0]  ws_q;
  logic [10:0] fw_q;
  logic [12:0] fh_q;

  logic [3:0]  n_w;
  logic [2:0]  rad;
  logic [3:0]  nm1;
  logic [7:0]  nn;
  logic [ColW-1:0] wm1;
  logic [HRowW-1:0] hm1;

  always_comb begin
    n_w = (ws_q == 4'd0) ? 4'd1 : ws_q;
    // round an even edge down to odd
    rad = n_w[3:1] - {2'b00, ~n_w[0]};
    nm1 = {rad, 1'b0};
    nn  = 8'({4'd0, nm1 + 4'd1} * {4'd0, nm1 + 4'd1});
    if (fw_q == 11'd0) wm1 = '0;
    else if (fw_q > 11'(MaxWidth)) wm1 = ColW'(MaxWidth - 1);
    else wm1 = ColW'(fw_q - 11'd1);
    if (fh_q == 13'd0) hm1 = '0;
    else if (fh_q > 13'd4096) hm1 = '1;
    else hm1 = HRowW'(fh_q - 13'd1);
  end

  // input position
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  icol_q;
  logic [SlotW-1:0] islot_q;

  logic in_img, valid_item, x_last, x_ge_rad, emit;
  logic [ColW-1:0] c0, c1;
  logic fdone_row;
  logic signed [13:0] raw_base;
  logic [4:0] slot_tmp;
  logic [SlotW-1:0] slot_base;

  always_comb begin
    in_img     = row_q <= {1'b0, hm1};
    valid_item = in_img ? !s_axis_tuser : s_axis_tuser;
    x_last     = icol_q == wm1;
    x_ge_rad   = icol_q >= ColW'(rad);
    emit       = valid_item && (row_q >= RowW'(rad)) && (x_last || x_ge_rad);
    c0         = x_ge_rad ? icol_q - ColW'(rad) : '0;
    c1         = x_last ? icol_q : icol_q - ColW'(rad);
    fdone_row  = (row_q - RowW'(rad)) == {1'b0, hm1};
    raw_base   = $signed({1'b0, row_q}) - $signed(14'({rad, 1'b0}));
    slot_tmp   = {1'b0, islot_q} - {1'b0, rad, 1'b0};
    slot_base  = slot_tmp[4] ? SlotW'(slot_tmp + 5'(Slots)) : slot_tmp[SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= 4'd3;
      fw_q <= 11'd640;
      fh_q <= 13'd480;
      row_q <= '0;
      icol_q <= '0;
      islot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowSize:  ws_q <= cfg_wdata_i[3:0];
        CfgFrameWidth:  fw_q <= cfg_wdata_i[10:0];
        CfgFrameHeight: fh_q <= cfg_wdata_i;
        default: ;
      endcase
      if (cfg_idx_i != 2'd3) begin
        row_q <= '0;
        icol_q <= '0;
        islot_q <= '0;
      end
    end else if (cmd_i.accept && valid_item) begin
      if (x_last) begin
        icol_q <= '0;
        if (row_q == RowW'({1'b0, hm1} + RowW'(rad))) begin
          row_q <= '0;
          islot_q <= '0;
        end else begin
          row_q <= row_q + RowW'(1);
          islot_q <= (islot_q == SlotW'(Slots - 1)) ? '0 : islot_q + SlotW'(1);
        end
      end else begin
        icol_q <= icol_q + ColW'(1);
      end
    end
  end

  // per-output window walk
  logic [ColW-1:0]   ocol_q, c1_q;
  logic              fdrow_q;
  logic signed [13:0] rbase_q, raw_q;
  logic [SlotW-1:0]  sbase_q, wslot_q;
  logic [3:0]        dr_q, dc_q;
  logic              rd_v_q;
  logic [SumW-1:0]   acc_q;
  logic [7:0]        rdata_q;
  logic [7:0]        store_q [0:StoreDepth-1];

  logic signed [11:0] cc_s;
  logic [ColW-1:0]    cc;
  logic [SlotW-1:0]   rslot;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               row_adv;

  always_comb begin
    cc_s = $signed({2'b00, ocol_q}) + $signed({8'd0, dc_q}) - $signed({9'd0, rad});
    if (cc_s < 0) cc = '0;
    else if (cc_s > $signed({2'b00, wm1})) cc = wm1;
    else cc = cc_s[ColW-1:0];
    rslot   = raw_q[13] ? '0 : wslot_q;
    rd_addr = {rslot, cc};
    wr_addr = {islot_q, icol_q};
    row_adv = raw_q[13] || (raw_q[12:0] < {1'b0, hm1});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && valid_item && in_img) begin
      store_q[wr_addr] <= s_axis_tdata;
    end
    if (cmd_i.rd_step) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c1_q <= c1;
      fdrow_q <= fdone_row;
      rbase_q <= raw_base;
      sbase_q <= slot_base;
    end
    if (cmd_i.col_start) begin
      ocol_q <= cmd_i.accept ? c0 : ocol_q + ColW'(1);
      dr_q <= '0;
      dc_q <= '0;
      raw_q <= cmd_i.accept ? raw_base : rbase_q;
      wslot_q <= cmd_i.accept ? slot_base : sbase_q;
      acc_q <= '0;
    end else begin
      if (cmd_i.rd_step) begin
        if (dc_q == nm1) begin
          dc_q <= '0;
          dr_q <= dr_q + 4'd1;
          // clamp at the bottom row: hold once the last image row is reached
          if (row_adv) begin
            raw_q <= raw_q + 14'sd1;
            wslot_q <= (wslot_q == SlotW'(Slots - 1)) ? '0 : wslot_q + SlotW'(1);
          end
        end else begin
          dc_q <= dc_q + 4'd1;
        end
      end
      if (rd_v_q) acc_q <= acc_q + SumW'(rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_step;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SumW-1:0] dq_q;
  logic [7:0]      rem_q;
  logic [3:0]      dcnt_q;
  logic [8:0]      rem_t, rem_s;
  logic            ge;

  always_comb begin
    rem_t = {rem_q, dq_q[SumW-1]};
    ge    = rem_t >= {1'b0, nn};
    rem_s = rem_t - {1'b0, nn};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dq_q <= acc_q;
      rem_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_s[7:0] : rem_t[7:0];
      dq_q <= {dq_q[SumW-2:0], ge};
      dcnt_q <= dcnt_q + 4'd1;
    end
  end

  always_comb begin
    m_axis_tdata  = dq_q[7:0];
    m_axis_tlast  = ocol_q == c1_q;
    m_axis_tuser  = fdrow_q && (ocol_q == wm1);
    sts_o.emit     = emit;
    sts_o.rd_last  = (dr_q == nm1) && (dc_q == nm1);
    sts_o.div_last = dcnt_q == 4'd15;
    sts_o.col_last = ocol_q == c1_q;
  end

endmodule
`default_nettype wire

>>> rtl/box_filter_replicate_border_unit.sv
// Top level of the N x N box filter with replicated borders.
// Depends on bfrb_pkg, bfrb_ctrl and bfrb_datapath.
//
// Pixels arrive in raster order on the slave stream (tuser 0), followed by
// (N-1)/2 rows of drain words (tuser 1) that stand for the replicated rows
// below the frame. A word that completes no window is taken without leaving
// the idle state. Each filtered pixel takes N*N window reads from the line
// store, one sample a cycle, a flush state for the last read, a load state
// and 16 steps of a restoring divider, then the output state until the result
// is taken; the word is first taken in the idle state. A word at a row end
// yields up to (N+1)/2 results. Only one word is in flight, and the input is
// held off while its results are produced. Register writes restart the frame
// and must be made only while the block is idle; it does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module box_filter_replicate_border_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [bfrb_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [7:0]                s_axis_tdata,  // [7:0] pixel_in
  input  wire logic                      s_axis_tuser,  // [0] kind
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] pixel_out
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser   // [0] frame_done
);
  import bfrb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfrb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  bfrb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for box_filter_replicate_border_unit.
// Streams small frames with drain rows and checks every filtered pixel; needs bfrb_pkg.
`timescale 1ns / 1ps
module testbench;
  import bfrb_pkg::*;

  localparam int LineRows = 2 * MaxRadius + 1;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       done;
  } filt_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  box_filter_replicate_border_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow state of the filter
  logic [3:0] win_reg;
  logic [10:0] wid_reg;
  logic [12:0] hgt_reg;
  logic [7:0] lines [LineRows * MaxWidth];
  int unsigned row_pos, col_pos;
  filt_word_t pending_q[$];
  int fail_count = 0;
  int cycles = 0;
  int out_idle = 0;
  bit stall_en = 1'b1;

  function automatic int unsigned radius();
    int unsigned n;
    n = win_reg;
    if (n == 0) n = 1;
    if (n % 2 == 0) n = n - 1;
    return ((n - 1) / 2 > MaxRadius) ? MaxRadius : (n - 1) / 2;
  endfunction

  function automatic int unsigned width_eff();
    return (wid_reg == 0) ? 1 : (wid_reg > MaxWidth) ? MaxWidth : wid_reg;
  endfunction

  function automatic int unsigned height_eff();
    return (hgt_reg == 0) ? 1 : (hgt_reg > 4096) ? 4096 : hgt_reg;
  endfunction

  function automatic logic [7:0] box_mean(int r, int c, int rad, int w, int h);
    int unsigned sum;
    int rr, cc;
    sum = 0;
    for (int dr = -rad; dr <= rad; dr++) begin
      rr = r + dr;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      for (int dc = -rad; dc <= rad; dc++) begin
        cc = c + dc;
        if (cc < 0) cc = 0;
        if (cc > w - 1) cc = w - 1;
        sum += lines[(rr % LineRows) * MaxWidth + cc];
      end
    end
    return 8'((sum / ((2 * rad + 1) * (2 * rad + 1))) & 255);
  endfunction

  // Advance the shadow state for one accepted word and queue its outputs
  task automatic predict_filter(logic kind, logic [7:0] pix);
    int unsigned rad, w, h, y, x, c0, c1;
    filt_word_t fw;
    rad = radius(); w = width_eff(); h = height_eff();
    y = row_pos; x = col_pos;
    if (x >= w) x = 0;
    if (y >= h + rad) y = 0;
    if (y < h) begin
      if (kind) return;
      lines[(y % LineRows) * MaxWidth + x] = pix;
    end else if (!kind) begin
      return;
    end
    if (y >= rad && (x == w - 1 || x >= rad)) begin
      c0 = (x >= rad) ? x - rad : 0;
      c1 = (x == w - 1) ? x : c0;
      for (int unsigned c = c0; c <= c1; c++) begin
        fw.pixel = box_mean(y - rad, c, rad, w, h);
        fw.last = (c == c1);
        fw.done = (y - rad == h - 1) && (c == w - 1);
        pending_q.push_back(fw);
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h + rad) y = 0;
    end
    row_pos = y; col_pos = x;
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CfgW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgWindowSize: win_reg = 4'(val);
      CfgFrameWidth: wid_reg = 11'(val);
      default: hgt_reg = 13'(val);
    endcase
    row_pos = 0; col_pos = 0;
  endtask

  task automatic send_word(logic kind, logic [7:0] pix);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_filter(kind, pix);
    @(negedge clk_i);
  endtask

  // One frame; pixel values from a chosen mode, drain rows appended
  task automatic send_frame(int mode);
    int unsigned w, h, rad;
    logic [7:0] v;
    w = width_eff(); h = height_eff(); rad = radius();
    for (int unsigned i = 0; i < w * h; i++) begin
      v = (mode == 0) ? 8'hFF : (mode == 1) ? 8'h00 : 8'($urandom);
      send_word(1'b0, v);
    end
    for (int unsigned i = 0; i < w * rad; i++) send_word(1'b1, 8'($urandom));
  endtask

  task automatic test_reset_config();
    // Extremes of the input field on the reset geometry would be long; shrink first
    write_reg(CfgFrameWidth, 3);
    write_reg(CfgFrameHeight, 2);
    send_frame(0);
    send_frame(1);
  endtask

  task automatic test_special_cases();
    write_reg(CfgWindowSize, 0);
    send_word(1'b1, 8'hA5);
    send_frame(2);
    write_reg(CfgWindowSize, 2);
    write_reg(CfgFrameWidth, 0);
    write_reg(CfgFrameHeight, 0);
    send_frame(2);
    send_word(1'b1, 8'h5A);   // drain word with a window of one: dropped
    write_reg(CfgWindowSize, 15);
    write_reg(CfgFrameWidth, 2);
    write_reg(CfgFrameHeight, 1);
    send_word(1'b1, 8'h11);   // drain during image rows: dropped
    send_word(1'b0, 8'h80);
    send_word(1'b0, 8'h7F);
    send_word(1'b0, 8'h01);   // pixel during drain rows: dropped
    for (int i = 0; i < 14; i++) send_word(1'b1, 8'h00);
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    for (int k = 0; k < 3; k++) begin
      write_reg(CfgWindowSize, $urandom_range(0, 15));
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 8);
      if (w > 16 || w == 0) w = ($urandom_range(0, 1)) ? 16 : 2047;
      write_reg(CfgFrameWidth, w);
      h = $urandom_range(0, 5);
      write_reg(CfgFrameHeight, ($urandom_range(0, 19) == 0) ? 13'h1FFF : h);
      // mostly words of the expected kind, now and then the wrong one
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 9) == 0) send_word(1'(row_pos < height_eff()), 8'($urandom));
        else send_word(row_pos >= height_eff(), 8'($urandom));
      end
    end
  endtask

  task automatic test_wide_frame();
    write_reg(CfgWindowSize, 15);
    write_reg(CfgFrameWidth, MaxWidth);
    write_reg(CfgFrameHeight, 1);
    stall_en = 1'b0;
    for (int i = 0; i < 40; i++) send_word(1'b0, 8'($urandom));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    filt_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_w = pending_q.pop_front();
        if (m_axis_tdata !== exp_w.pixel) begin
          $error("pixel_out expected %0d actual %0d", exp_w.pixel, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $error("run_last expected %0d actual %0d", exp_w.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== exp_w.done) begin
          $error("frame_done expected %0d actual %0d", exp_w.done, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Random output back-pressure in bursts
  always @(negedge clk_i) begin
    if (!stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (out_idle > 0) begin
      out_idle--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_idle = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    win_reg = 4'd3; wid_reg = 11'd640; hgt_reg = 13'd480;
    row_pos = 0; col_pos = 0;
    for (int i = 0; i < LineRows * MaxWidth; i++) lines[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_config();
    test_special_cases();
    test_random_frames();
    test_wide_frame();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

>>> filelist.f
rtl/bfrb_pkg.sv
rtl/bfrb_ctrl.sv
rtl/bfrb_datapath.sv
rtl/box_filter_replicate_border_unit.sv
tb/testbench.sv
